// ===== rtl/core/izh_pkg.sv =====
// Izhikevich neuron step: shared constants, types, fixed-point helpers and microcode ROM.
// Depends on nothing; used by izh_seq, izh_dp and izhikevich_neuron_step.
package izh_pkg;

	localparam int FRAC_BITS = 16;
	localparam longint ONE_FX = longint'(1) << FRAC_BITS;

	localparam logic signed [31:0] K_004 = 32'((4 * ONE_FX + 50) / 100);
	localparam logic signed [31:0] K_5   = 32'(5 * ONE_FX);
	localparam logic signed [31:0] K_140 = 32'(140 * ONE_FX);
	localparam logic signed [31:0] K_30  = 32'(30 * ONE_FX);

	localparam longint RST_A_L    = (2 * ONE_FX + 50) / 100;
	localparam longint RST_B_L    = (2 * ONE_FX + 5) / 10;
	localparam longint RST_C_L    = -65 * ONE_FX;
	localparam longint RST_D_L    = 8 * ONE_FX;
	localparam longint RST_REST_L = -70 * ONE_FX;
	localparam longint RST_U_L    =
		(RST_B_L * RST_REST_L + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;

	localparam logic signed [31:0] RST_A    = 32'(RST_A_L);
	localparam logic signed [31:0] RST_B    = 32'(RST_B_L);
	localparam logic signed [31:0] RST_C    = 32'(RST_C_L);
	localparam logic signed [31:0] RST_D    = 32'(RST_D_L);
	localparam logic signed [31:0] RST_REST = 32'(RST_REST_L);
	localparam logic signed [31:0] RST_U    = 32'(RST_U_L);

	typedef enum logic [2:0] {
		CFG_A    = 3'd0,
		CFG_B    = 3'd1,
		CFG_C    = 3'd2,
		CFG_D    = 3'd3,
		CFG_REST = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
		logic signed [31:0] rest;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_SPIKE,
		OP_T,
		OP_HALF,
		OP_W,
		OP_U,
		OP_REST,
		OP_USET
	} op_t;

	typedef enum logic [1:0] {
		MA_K004,
		MA_V,
		MA_B,
		MA_A
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_V,
		MB_T,
		MB_REST
	} mul_b_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_REST = 4'd14;

	typedef struct packed {
		op_t    op;
		logic   mul_en;
		mul_a_t ma;
		mul_b_t mb;
		logic   br_rest;
		step_t  target;
		logic   last;
	} cw_t;

	typedef struct packed {
		logic act;
		cw_t  cw;
	} ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// round-half-up then floor shift, saturated
	function automatic logic signed [31:0] fmul_post(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return sat32(r);
	endfunction

	function automatic cw_t mc(input op_t op, input logic mul_en, input mul_a_t ma,
		input mul_b_t mb, input logic last);
		cw_t w;
		w.op      = op;
		w.mul_en  = mul_en;
		w.ma      = ma;
		w.mb      = mb;
		w.br_rest = 1'b0;
		w.target  = '0;
		w.last    = last;
		return w;
	endfunction

	function automatic cw_t ucode(input step_t step);
		cw_t w;
		unique case (step)
			4'd0: begin
				w = mc(OP_NOP, 1'b0, MA_V, MB_V, 1'b0);
				w.br_rest = 1'b1;
				w.target  = STEP_REST;
			end
			4'd1:  w = mc(OP_SPIKE, 1'b0, MA_V,    MB_V,    1'b0);
			4'd2:  w = mc(OP_NOP,   1'b1, MA_K004, MB_V,    1'b0);
			4'd3:  w = mc(OP_T,     1'b0, MA_V,    MB_V,    1'b0);
			4'd4:  w = mc(OP_NOP,   1'b1, MA_V,    MB_T,    1'b0);
			4'd5:  w = mc(OP_HALF,  1'b0, MA_V,    MB_V,    1'b0);
			4'd6:  w = mc(OP_NOP,   1'b1, MA_K004, MB_V,    1'b0);
			4'd7:  w = mc(OP_T,     1'b0, MA_V,    MB_V,    1'b0);
			4'd8:  w = mc(OP_NOP,   1'b1, MA_V,    MB_T,    1'b0);
			4'd9:  w = mc(OP_HALF,  1'b0, MA_V,    MB_V,    1'b0);
			4'd10: w = mc(OP_NOP,   1'b1, MA_B,    MB_V,    1'b0);
			4'd11: w = mc(OP_W,     1'b0, MA_V,    MB_V,    1'b0);
			4'd12: w = mc(OP_NOP,   1'b1, MA_A,    MB_T,    1'b0);
			4'd13: w = mc(OP_U,     1'b0, MA_V,    MB_V,    1'b1);
			4'd14: w = mc(OP_REST,  1'b1, MA_B,    MB_REST, 1'b0);
			4'd15: w = mc(OP_USET,  1'b0, MA_V,    MB_V,    1'b1);
			default: w = mc(OP_NOP, 1'b0, MA_V,    MB_V,    1'b1);
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/izh_seq.sv =====
// Izhikevich neuron step: microcode sequencer (step counter, ROM fetch, rest branch).
// Depends on izh_pkg.
module izh_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            start_mode,
	input  logic            out_blocked,
	output logic            busy,
	output izh_pkg::ctl_t   ctl
);

	logic               busy_q;
	logic               mode_q;
	izh_pkg::step_t     step_q;
	izh_pkg::cw_t       cw;
	logic               act;

	assign cw   = izh_pkg::ucode(step_q);
	// hold on the final step until the output register is free
	assign act  = busy_q && !(cw.last && out_blocked);
	assign busy = busy_q;
	assign ctl  = '{act: act, cw: cw};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			mode_q <= start_mode;
			step_q <= '0;
		end else if (act) begin
			if (cw.last) begin
				busy_q <= 1'b0;
			end else if (cw.br_rest && mode_q) begin
				step_q <= cw.target;
			end else begin
				step_q <= step_q + 4'd1;
			end
		end
	end

endmodule

// ===== rtl/core/izh_dp.sv =====
// Izhikevich neuron step: datapath with one shared registered multiplier and state v, u.
// Depends on izh_pkg; driven by the control word from izh_seq.
module izh_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  izh_pkg::ctl_t       ctl,
	input  logic                load,
	input  logic signed [31:0]  input_current,
	input  izh_pkg::cfg_t       cfg,
	output logic signed [31:0]  v,
	output logic                spk
);

	logic signed [31:0] v_q;
	logic signed [31:0] u_q;
	logic signed [31:0] t_q;
	logic signed [31:0] cur_q;
	logic signed [63:0] p_q;
	logic               spk_q;

	logic signed [31:0] ma;
	logic signed [31:0] mb;
	logic signed [31:0] fm;
	logic signed [32:0] t_sum;
	logic signed [34:0] s_sum;
	logic signed [34:0] s_half;
	logic signed [35:0] v_sum;
	logic signed [32:0] w_sum;
	logic signed [32:0] u_sum;
	logic signed [32:0] ud_sum;

	always_comb begin
		unique case (ctl.cw.ma)
			izh_pkg::MA_K004: ma = izh_pkg::K_004;
			izh_pkg::MA_V:    ma = v_q;
			izh_pkg::MA_B:    ma = cfg.b;
			izh_pkg::MA_A:    ma = cfg.a;
			default:          ma = v_q;
		endcase
		unique case (ctl.cw.mb)
			izh_pkg::MB_V:    mb = v_q;
			izh_pkg::MB_T:    mb = t_q;
			izh_pkg::MB_REST: mb = cfg.rest;
			default:          mb = v_q;
		endcase
	end

	assign fm     = izh_pkg::fmul_post(p_q);
	assign t_sum  = 33'(fm) + 33'(izh_pkg::K_5);
	assign s_sum  = 35'(fm) + 35'(izh_pkg::K_140) - 35'(u_q) + 35'(cur_q);
	assign s_half = (s_sum + 35'sd1) >>> 1;
	assign v_sum  = 36'(v_q) + 36'(s_half);
	assign w_sum  = 33'(fm) - 33'(u_q);
	assign u_sum  = 33'(u_q) + 33'(fm);
	assign ud_sum = 33'(u_q) + 33'(cfg.d);

	always_ff @(posedge clk) begin
		if (ctl.act && ctl.cw.mul_en) begin
			p_q <= 64'(ma) * 64'(mb);
		end
		if (load) begin
			cur_q <= input_current;
		end
		if (ctl.act) begin
			case (ctl.cw.op)
				izh_pkg::OP_T: t_q <= izh_pkg::sat32(64'(t_sum));
				izh_pkg::OP_W: t_q <= izh_pkg::sat32(64'(w_sum));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= izh_pkg::RST_REST;
			u_q   <= izh_pkg::RST_U;
			spk_q <= 1'b0;
		end else if (load) begin
			spk_q <= 1'b0;
		end else if (ctl.act) begin
			case (ctl.cw.op)
				izh_pkg::OP_SPIKE: begin
					if (v_q >= izh_pkg::K_30) begin
						spk_q <= 1'b1;
						v_q   <= cfg.c;
						u_q   <= izh_pkg::sat32(64'(ud_sum));
					end
				end
				izh_pkg::OP_HALF: v_q <= izh_pkg::sat32(64'(v_sum));
				izh_pkg::OP_U:    u_q <= izh_pkg::sat32(64'(u_sum));
				izh_pkg::OP_REST: v_q <= cfg.rest;
				izh_pkg::OP_USET: u_q <= fm;
				default: ;
			endcase
		end
	end

	assign v   = v_q;
	assign spk = spk_q;

endmodule

// ===== rtl/core/izhikevich_neuron_step.sv =====
// Izhikevich neuron step: top level with handshakes, configuration registers, output register.
// Depends on izh_pkg, izh_seq and izh_dp.
//
//  channel | signals                               | dir | accepted when
//  in      | in_valid/in_ready, mode, input_current | in  | in_valid && in_ready
//  out     | out_valid/out_ready, potential, spike  | out | out_valid && out_ready
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | in | cfg_valid (ready always high)
//
// Step items run ucode steps 0 to 13, rest items steps 0, 14, 15; one control word is
// issued per cycle unless the last step is held; the single 32x32 multiplier is registered.
// in_ready is high whenever the sequencer is idle, also while a result waits in the output
// register; a finished item holds on its last step until that register is free.
// Reset loads the configuration reset values, v = -70.0 and u = b*v.
module izhikevich_neuron_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic signed [31:0] input_current,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] potential,
	output logic               spike,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	izh_pkg::cfg_t      cfg_q;
	izh_pkg::ctl_t      ctl;
	logic               busy;
	logic               start;
	logic               out_valid_q;
	logic signed [31:0] potential_q;
	logic               spike_q;
	logic signed [31:0] v;
	logic               spk;

	assign in_ready  = !busy;
	assign cfg_ready = 1'b1;
	assign start     = in_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a    <= izh_pkg::RST_A;
			cfg_q.b    <= izh_pkg::RST_B;
			cfg_q.c    <= izh_pkg::RST_C;
			cfg_q.d    <= izh_pkg::RST_D;
			cfg_q.rest <= izh_pkg::RST_REST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				izh_pkg::CFG_A:    cfg_q.a    <= cfg_data;
				izh_pkg::CFG_B:    cfg_q.b    <= cfg_data;
				izh_pkg::CFG_C:    cfg_q.c    <= cfg_data;
				izh_pkg::CFG_D:    cfg_q.d    <= cfg_data;
				izh_pkg::CFG_REST: cfg_q.rest <= cfg_data;
				default: ;
			endcase
		end
	end

	izh_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.start_mode  (mode),
		.out_blocked (out_valid_q && !out_ready),
		.busy        (busy),
		.ctl         (ctl)
	);

	izh_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.load          (start),
		.input_current (input_current),
		.cfg           (cfg_q),
		.v             (v),
		.spk           (spk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.act && ctl.cw.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.act && ctl.cw.last) begin
			potential_q <= v;
			spike_q     <= spk;
		end
	end

	assign out_valid = out_valid_q;
	assign potential = potential_q;
	assign spike     = spike_q;

endmodule

// ===== tb/testbench.sv =====
// Testbench for izhikevich_neuron_step: a directed table, then phases of random items under
// several register settings, results checked against an in-bench fixed-point neuron or table.
// Depends on izh_pkg and the RTL of izhikevich_neuron_step.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint Q_ONE  = longint'(1) << izh_pkg::FRAC_BITS;
	localparam longint Q_HALF = longint'(1) << (izh_pkg::FRAC_BITS - 1);
	localparam longint Q_004  = (4 * Q_ONE + 50) / 100;
	localparam longint Q_5    = 5 * Q_ONE;
	localparam longint Q_140  = 140 * Q_ONE;
	localparam longint Q_30   = 30 * Q_ONE;

	localparam logic MODE_STEP = 1'b0;
	localparam logic MODE_REST = 1'b1;

	// indexes past the last register, writes there are dropped
	localparam logic [2:0] IDX_NONE_LO  = 3'd5;
	localparam logic [2:0] IDX_NONE_MID = 3'd6;
	localparam logic [2:0] IDX_NONE_HI  = 3'd7;

	localparam logic EXACT    = 1'b1;
	localparam logic MODELLED = 1'b0;

	localparam int unsigned LIMIT           = 1000000;
	localparam int          PHASES          = 10;
	localparam int          ITEMS_PER_PHASE = 110;
	localparam int          CALM_PHASE      = 3;
	localparam int          DRAIN_CYCLES    = 30;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [31:0] data;
		logic        md;
		logic [31:0] cur;
		logic        typed;
		logic [31:0] pot;
		logic        spk;
	} drow_t;

	typedef struct packed {
		logic signed [31:0] potential;
		logic               spike;
	} reading_t;

	typedef enum logic [2:0] {
		PF_REGULAR,
		PF_FAST,
		PF_CHATTER,
		PF_BURST,
		PF_WILD,
		PF_EDGE
	} profile_t;

	localparam profile_t PHASE_PLAN [PHASES] = '{
		PF_REGULAR, PF_FAST, PF_WILD, PF_CHATTER, PF_EDGE,
		PF_REGULAR, PF_BURST, PF_WILD, PF_EDGE, PF_FAST
	};

	localparam int NUM_ROWS = 42;

	localparam drow_t DIRECTED [NUM_ROWS] = '{
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h0000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h7fff_ffff, EXACT, 32'hffba_0000, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h7fff_ffff, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h0000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h8000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h8000_0000, EXACT, 32'hffba_0000, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_REST, 32'h7fff_ffff, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h0000_0000, EXACT, 32'h7fff_ffff, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h0000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_REST, 32'h8000_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h1234_5678, EXACT, 32'h8000_0000, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h8000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_A, 32'h7fff_ffff, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_B, 32'h8000_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_C, 32'h7fff_ffff, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_D, 32'h7fff_ffff, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h0000_0000, EXACT, 32'h8000_0000, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h7fff_ffff, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h0000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_A, 32'h8000_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_B, 32'h7fff_ffff, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_C, 32'h8000_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_D, 32'h8000_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h8000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'hffff_ffff, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, IDX_NONE_LO, 32'h0000_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, IDX_NONE_MID, 32'hffff_ffff, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, IDX_NONE_HI, 32'h5a5a_5a5a, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h0000_0000, EXACT, 32'h8000_0000, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_A, 32'h0000_051f, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_B, 32'h0000_3333, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_C, 32'hffbf_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_D, 32'h0008_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_REST, 32'h001e_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h0000_0000, EXACT, 32'h001e_0000, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h0000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_REST, 32'h001d_ffff, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h0000_0000, EXACT, 32'h001d_ffff, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h0000_0000, MODELLED, 32'h0, 1'b0},
		'{ROW_CFG, izh_pkg::CFG_REST, 32'hffba_0000, MODE_STEP, 32'h0, MODELLED, 32'h0, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_REST, 32'h0000_0000, EXACT, 32'hffba_0000, 1'b0},
		'{ROW_ITEM, 3'd0, 32'h0, MODE_STEP, 32'h000a_0000, MODELLED, 32'h0, 1'b0}
	};

	logic               clk;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic               mode          = MODE_STEP;
	logic signed [31:0] input_current = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic signed [31:0] potential;
	logic               spike;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index     = '0;
	logic [31:0]        cfg_data      = '0;

	izh_pkg::cfg_t      nc;
	logic signed [31:0] mem_v;
	logic signed [31:0] rec_u;
	reading_t           readings [$];
	reading_t           want;
	int unsigned        n_errors  = 0;
	int unsigned        hold_left = 0;
	bit                 calm      = 1'b0;
	bit                 cfg_open  = 1'b0;

	izhikevich_neuron_step u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.input_current (input_current),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.potential     (potential),
		.spike         (spike),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("[izhikevich_neuron_step] ERROR");
		$finish;
	end

	function automatic logic signed [31:0] clamp32(input longint x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] qmul(input longint x, input longint y);
		longint p;
		p = x * y + Q_HALF;
		return clamp32(p >>> izh_pkg::FRAC_BITS);
	endfunction

	function automatic logic signed [31:0] euler_half(input logic signed [31:0] v,
		input logic signed [31:0] u, input logic signed [31:0] cur);
		logic signed [31:0] t;
		longint             s;
		t = clamp32(longint'(qmul(Q_004, v)) + Q_5);
		s = longint'(qmul(v, t)) + Q_140 - longint'(u) + longint'(cur);
		return clamp32(longint'(v) + ((s + 1) >>> 1));
	endfunction

	function automatic void reset_neuron();
		nc.a    = 32'((2 * Q_ONE + 50) / 100);
		nc.b    = 32'((2 * Q_ONE + 5) / 10);
		nc.c    = 32'(-65 * Q_ONE);
		nc.d    = 32'(8 * Q_ONE);
		nc.rest = 32'(-70 * Q_ONE);
		mem_v   = nc.rest;
		rec_u   = qmul(nc.b, nc.rest);
	endfunction

	function automatic void load_reg(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			izh_pkg::CFG_A:    nc.a    = val;
			izh_pkg::CFG_B:    nc.b    = val;
			izh_pkg::CFG_C:    nc.c    = val;
			izh_pkg::CFG_D:    nc.d    = val;
			izh_pkg::CFG_REST: nc.rest = val;
			default:  ;
		endcase
	endfunction

	function automatic reading_t tick_neuron(input logic md, input logic signed [31:0] cur);
		logic signed [31:0] v;
		logic signed [31:0] u;
		logic signed [31:0] w;
		reading_t           r;
		v = mem_v;
		u = rec_u;
		r.spike = 1'b0;
		if (md == MODE_REST) begin
			v = nc.rest;
			u = qmul(nc.b, v);
		end else begin
			if (longint'(v) >= Q_30) begin
				r.spike = 1'b1;
				v = nc.c;
				u = clamp32(longint'(u) + longint'(nc.d));
			end
			v = euler_half(v, u, cur);
			v = euler_half(v, u, cur);
			w = clamp32(longint'(qmul(nc.b, v)) - longint'(u));
			u = clamp32(longint'(u) + longint'(qmul(nc.a, w)));
		end
		mem_v = v;
		rec_u = u;
		r.potential = v;
		return r;
	endfunction

	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 3))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// mostly a physiological drive of -5.0 to 25.0, some full-range noise and edge values
	function automatic logic [31:0] pick_current();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 8) begin
			return 32'($urandom_range(0, 30 * Q_ONE)) - 32'(5 * Q_ONE);
		end
		if (r == 8) begin
			return $urandom;
		end
		return edge_value();
	endfunction

	function automatic izh_pkg::cfg_t phase_settings(input profile_t pf);
		izh_pkg::cfg_t s;
		s.a    = 32'd1311;
		s.b    = 32'd13107;
		s.c    = 32'(-65 * Q_ONE);
		s.d    = 32'(8 * Q_ONE);
		s.rest = 32'(-70 * Q_ONE) + 32'($urandom_range(0, 10 * Q_ONE)) - 32'(5 * Q_ONE);
		case (pf)
			PF_FAST: begin
				s.a = 32'd6554;
				s.d = 32'(2 * Q_ONE);
			end
			PF_CHATTER: begin
				s.c = 32'(-50 * Q_ONE);
				s.d = 32'(2 * Q_ONE);
			end
			PF_BURST: begin
				s.c = 32'(-55 * Q_ONE);
				s.d = 32'(4 * Q_ONE);
			end
			PF_WILD: begin
				s.a    = $urandom;
				s.b    = $urandom;
				s.c    = $urandom;
				s.d    = $urandom;
				s.rest = $urandom;
			end
			PF_EDGE: begin
				s.a    = edge_value();
				s.b    = edge_value();
				s.c    = edge_value();
				s.d    = edge_value();
				s.rest = edge_value();
			end
			default: ;
		endcase
		if (pf != PF_WILD && pf != PF_EDGE) begin
			s.a = s.a + 32'($urandom_range(0, 200)) - 32'd100;
			s.b = s.b + 32'($urandom_range(0, 200)) - 32'd100;
		end
		return s;
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (readings.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		if (!cfg_open) begin
			settle();
			cfg_open = 1'b1;
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		load_reg(idx, val);
	endtask

	task automatic send_item(input logic md, input logic [31:0] cur, input logic typed,
		input logic [31:0] pot, input logic spk);
		int unsigned pause;
		reading_t    r;
		pause = pick_pause();
		if (cfg_open) begin
			cfg_valid <= 1'b0;
			cfg_open = 1'b0;
		end
		if (pause != 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= md;
		input_current <= cur;
		do @(posedge clk); while (!in_ready);
		r = tick_neuron(md, cur);
		if (typed) begin
			r.potential = pot;
			r.spike     = spk;
		end
		readings.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (readings.size() == 0) begin
					n_errors++;
					$error("result item with none expected: potential %0d spike %0b",
						potential, spike);
				end else begin
					want = readings.pop_front();
					if (potential !== want.potential) begin
						n_errors++;
						$error("potential: expected %0d, got %0d", want.potential, potential);
					end
					if (spike !== want.spike) begin
						n_errors++;
						$error("spike: expected %0b, got %0b", want.spike, spike);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0) begin
					hold_left = pick_pause() + 1;
				end
			end
		end
	end

	initial begin
		izh_pkg::cfg_t next_cfg;
		logic md;
		reset_neuron();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[k]) begin
			if (DIRECTED[k].kind == ROW_CFG) begin
				write_reg(DIRECTED[k].idx, DIRECTED[k].data);
			end else begin
				send_item(DIRECTED[k].md, DIRECTED[k].cur, DIRECTED[k].typed,
					DIRECTED[k].pot, DIRECTED[k].spk);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			next_cfg = phase_settings(PHASE_PLAN[ph]);
			write_reg(izh_pkg::CFG_A, next_cfg.a);
			write_reg(izh_pkg::CFG_B, next_cfg.b);
			write_reg(izh_pkg::CFG_C, next_cfg.c);
			write_reg(izh_pkg::CFG_D, next_cfg.d);
			write_reg(izh_pkg::CFG_REST, next_cfg.rest);
			if ($urandom_range(0, 2) == 0) begin
				write_reg(IDX_NONE_LO + 3'($urandom_range(0, 2)), $urandom);
			end
			calm = (ph == CALM_PHASE);
			send_item(MODE_REST, $urandom, MODELLED, 32'h0, 1'b0);
			for (int n = 1; n < ITEMS_PER_PHASE; n++) begin
				md = ($urandom_range(0, 24) == 0) ? MODE_REST : MODE_STEP;
				send_item(md, pick_current(), MODELLED, 32'h0, 1'b0);
			end
		end
		calm = 1'b0;

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0) begin
			$display("[izhikevich_neuron_step] OK");
		end else begin
			$display("[izhikevich_neuron_step] ERROR");
		end
		$finish;
	end

endmodule
